>>> rtl/bb3_pkg.sv
// shared types, constants and helper functions for the 3x3 rgb box blur
// no dependencies; imported by every module of the block
`default_nettype none

package bb3_pkg;

    localparam int CH_W          = 8;
    localparam int PIX_W         = 3 * CH_W;
    localparam int LINE_W        = 2 * PIX_W;
    localparam int MAX_WIDTH_DEF = 1024;

    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int CFG_DATA_W = 16;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd768;

    // arithmetic widths: column sum of 3 taps, window sum of 9, 2*sum+count
    localparam int COLSUM_W    = CH_W + 2;
    localparam int SUM_W       = CH_W + 4;
    localparam int NUM_W       = SUM_W + 1;
    localparam int CNT_W       = 4;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 20;
    localparam int PROD_W      = NUM_W + RECIP_W;

    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_DRAIN = 1'b1
    } t_kind;

    typedef logic [PIX_W-1:0] t_pixel;

    // [column left..right][row top..bottom]
    typedef t_pixel [2:0][2:0] t_window;

    typedef struct packed {
        t_kind            kind;
        logic [CH_W-1:0]  red_in;
        logic [CH_W-1:0]  green_in;
        logic [CH_W-1:0]  blue_in;
    } t_in_req;

    typedef struct packed {
        logic [CH_W-1:0]  red_out;
        logic [CH_W-1:0]  green_out;
        logic [CH_W-1:0]  blue_out;
        logic             frame_end;
    } t_out_req;

    typedef struct packed {
        logic valid;
        logic has_left;
        logic has_right;
        logic has_top;
        logic has_bottom;
        logic frame_end;
    } t_emit_ctl;

    // number of window taps inside the image, centre included
    function automatic logic [CNT_W-1:0] tap_count(input logic l, input logic r,
                                                    input logic t, input logic b);
        logic [1:0] nc;
        logic [1:0] nr;
        nc = 2'd1 + {1'b0, l} + {1'b0, r};
        nr = 2'd1 + {1'b0, t} + {1'b0, b};
        return {2'b00, nc} * {2'b00, nr};
    endfunction

    // ceil(2^RECIP_SHIFT / (2*count)); exact for every numerator below 2^NUM_W
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        case (cnt)
            4'd1:    r = 20'd524288;
            4'd2:    r = 20'd262144;
            4'd3:    r = 20'd174763;
            4'd4:    r = 20'd131072;
            4'd6:    r = 20'd87382;
            4'd9:    r = 20'd58255;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/box_blur_3x3_rgb_core.sv
// 3x3 box blur of an rgb raster stream, one request per clock unless stalled.
// Input channel (i_in_valid / o_in_stall / i_in_req): pixels in raster order,
// kind = drain flushes the frame tail once all pixels of the frame are in;
// a drain that comes earlier is taken and dropped.
// Output channel (o_out_valid / i_out_stall / o_out_req): one blurred pixel,
// frame_end marks the last pixel of the frame.
// The result for pixel p is triggered by the request at stream position
// p + width + 1 and passes through the window, column sum, window sum and
// output registers before it shows on the output.
// Throughput: one request per cycle while not stalled, set by the single line
// store, which is read and written once per request.
// Stall: while a result waits in the output register under i_out_stall, the
// whole pipeline holds and o_in_stall is high.
// Reset: width 1024, height 768, counters cleared; no clearing pass, the line
// store content is unused until written within the frame.
// Config (i_cfg_we / i_cfg_idx / i_cfg_data): write only while idle; any write
// restarts the frame. Depends on bb3_pkg and the bb3_* modules.
`default_nettype none

module box_blur_3x3_rgb_core #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  bb3_pkg::t_cfg_reg              i_cfg_idx,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  bb3_pkg::t_in_req               i_in_req,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output bb3_pkg::t_out_req              o_out_req
);
    import bb3_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic              en;
    logic              accept;
    logic              out_valid;
    logic [COL_W-1:0]  rd_addr;
    logic              wr_en;
    logic [COL_W-1:0]  wr_addr;
    logic [LINE_W-1:0] wr_data;
    logic [LINE_W-1:0] line_q;
    t_emit_ctl         ctl;
    t_window           win;

    // pipeline moves unless a finished result is held by the receiver
    assign en         = !(out_valid && i_out_stall);
    assign accept     = i_in_valid && en;
    assign o_in_stall = !en;
    assign o_out_valid = out_valid;

    bb3_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (line_q)
    );

    bb3_scan #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_en       (en),
        .i_accept   (accept),
        .i_req      (i_in_req),
        .i_line_q   (line_q),
        .o_rd_addr  (rd_addr),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_ctl      (ctl),
        .o_win      (win)
    );

    bb3_average u_average (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (ctl),
        .i_win   (win),
        .o_valid (out_valid),
        .o_req   (o_out_req)
    );

endmodule

`default_nettype wire

>>> rtl/bb3_line_store.sv
// two-row line store: one synchronous memory, entry = {older row, newer row}
// depends on bb3_pkg; one write and one registered read per cycle, with bypass
`default_nettype none

module bb3_line_store #(
    parameter int DEPTH  = bb3_pkg::MAX_WIDTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  logic [bb3_pkg::LINE_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    output logic [bb3_pkg::LINE_W-1:0] o_rd_data
);
    import bb3_pkg::*;

    logic [LINE_W-1:0] r_mem [DEPTH];
    logic [LINE_W-1:0] r_q;
    logic [LINE_W-1:0] r_byp_data;
    logic              r_byp;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q        <= r_mem[i_rd_addr];
        r_byp_data <= i_wr_data;
    end

    // read of the entry written in the same cycle returns the new data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else begin
            r_byp <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_q;

    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_en && (i_wr_addr == i_rd_addr)) |=> (o_rd_data == $past(i_wr_data)))
        else $error("line store read misses a same-entry write");

endmodule

`default_nettype wire

>>> rtl/bb3_scan.sv
// raster scan control: frame registers, input and output counters, window
// depends on bb3_pkg; drives the line store and hands the window downstream
`default_nettype none

module bb3_scan #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF,
    parameter int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  bb3_pkg::t_cfg_reg              i_cfg_idx,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_en,
    input  logic                           i_accept,
    input  bb3_pkg::t_in_req               i_req,
    input  logic [bb3_pkg::LINE_W-1:0]     i_line_q,
    output logic [COL_W-1:0]               o_rd_addr,
    output logic                           o_wr_en,
    output logic [COL_W-1:0]               o_wr_addr,
    output logic [bb3_pkg::LINE_W-1:0]     o_wr_data,
    output bb3_pkg::t_emit_ctl             o_ctl,
    output bb3_pkg::t_window               o_win
);
    import bb3_pkg::*;

    logic [FW_W-1:0]  r_frame_width,  n_frame_width;
    logic [FH_W-1:0]  r_frame_height, n_frame_height;
    logic [COL_W-1:0] r_in_col,  n_in_col;
    logic [FH_W-1:0]  r_in_row,  n_in_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [FH_W-1:0]  r_out_row, n_out_row;
    logic             r_full,     n_full;
    logic             r_complete, n_complete;
    t_emit_ctl        r_ctl, n_ctl;
    t_window          r_win, n_win;

    logic [COL_W-1:0] wlast;
    logic [FH_W-1:0]  hlast;
    logic [31:0]      fw32;
    logic             step;
    logic             last_col;
    logic             out_row_last;
    logic             row_is_one;
    t_pixel           px;
    t_pixel           older;
    t_pixel           newer;

    always_comb begin
        fw32 = {{(32-FW_W){1'b0}}, r_frame_width};
        if (fw32 == 32'd0) begin
            wlast = '0;
        end else if (fw32 > 32'(MAX_WIDTH)) begin
            wlast = COL_W'(MAX_WIDTH - 1);
        end else begin
            wlast = COL_W'(fw32 - 32'd1);
        end
        hlast = (r_frame_height == '0) ? '0 : r_frame_height - 16'd1;
    end

    assign older = i_line_q[LINE_W-1 -: PIX_W];
    assign newer = i_line_q[PIX_W-1:0];
    assign px    = r_complete ? '0 : {i_req.red_in, i_req.green_in, i_req.blue_in};

    // a drain before the frame's last pixel is swallowed without effect
    assign step         = i_accept && !(i_req.kind == KIND_DRAIN && !r_complete);
    assign last_col     = (r_out_col == wlast);
    assign out_row_last = (r_out_row == hlast);
    assign row_is_one   = r_complete ? (hlast == '0) : (r_in_row == 16'd1);

    always_comb begin
        n_frame_width  = r_frame_width;
        n_frame_height = r_frame_height;
        n_in_col       = r_in_col;
        n_in_row       = r_in_row;
        n_out_col      = r_out_col;
        n_out_row      = r_out_row;
        n_full         = r_full;
        n_complete     = r_complete;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  n_frame_width  = i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: n_frame_height = i_cfg_data[FH_W-1:0];
            endcase
            n_in_col   = '0;
            n_in_row   = '0;
            n_out_col  = '0;
            n_out_row  = '0;
            n_full     = 1'b0;
            n_complete = 1'b0;
        end else if (step) begin
            if (row_is_one && r_in_col == '0) begin
                n_full = 1'b1;
            end
            if (r_in_col == wlast) begin
                n_in_col = '0;
                if (!r_complete) begin
                    if (r_in_row == hlast) begin
                        n_complete = 1'b1;
                    end else begin
                        n_in_row = r_in_row + 16'd1;
                    end
                end
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
            if (r_full) begin
                if (last_col) begin
                    n_out_col = '0;
                    if (out_row_last) begin
                        n_in_col   = '0;
                        n_in_row   = '0;
                        n_out_row  = '0;
                        n_full     = 1'b0;
                        n_complete = 1'b0;
                    end else begin
                        n_out_row = r_out_row + 16'd1;
                    end
                end else begin
                    n_out_col = r_out_col + COL_W'(1);
                end
            end
        end
    end

    // the shifted window serves both cases: center is the middle column and
    // the right column is dropped when the output sits on the last column
    always_comb begin
        n_win = r_win;
        if (step) begin
            n_win[0]    = r_win[1];
            n_win[1]    = r_win[2];
            n_win[2][0] = older;
            n_win[2][1] = newer;
            n_win[2][2] = px;
        end
        n_ctl.valid      = step && r_full && !i_cfg_we;
        n_ctl.has_left   = (r_out_col != '0);
        n_ctl.has_right  = !last_col;
        n_ctl.has_top    = (r_out_row != '0);
        n_ctl.has_bottom = !out_row_last;
        n_ctl.frame_end  = last_col && out_row_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
            r_full         <= 1'b0;
            r_complete     <= 1'b0;
            r_ctl          <= '0;
        end else begin
            r_frame_width  <= n_frame_width;
            r_frame_height <= n_frame_height;
            r_in_col       <= n_in_col;
            r_in_row       <= n_in_row;
            r_out_col      <= n_out_col;
            r_out_row      <= n_out_row;
            r_full         <= n_full;
            r_complete     <= n_complete;
            if (i_en) begin
                r_ctl <= n_ctl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    assign o_rd_addr = i_rst_n ? n_in_col : '0;
    assign o_wr_en   = step && !i_cfg_we;
    assign o_wr_addr = r_in_col;
    assign o_wr_data = {newer, px};
    assign o_ctl     = r_ctl;
    assign o_win     = r_win;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_col <= wlast) && (r_out_col <= wlast))
        else $error("column counter beyond frame width");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && !i_cfg_we && r_full && last_col && out_row_last) |=>
        (r_in_col == '0 && r_out_col == '0 && r_out_row == '0 && !r_full && !r_complete))
        else $error("frame end did not restart the scan");

    a_early_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_cfg_we && i_req.kind == KIND_DRAIN && !r_complete) |=>
        ($stable(r_in_col) && $stable(r_in_row) && $stable(r_out_col) && $stable(r_full)))
        else $error("early drain changed scan state");

endmodule

`default_nettype wire

>>> rtl/bb3_average.sv
// rounded neighbourhood average: column sums, window sum, reciprocal multiply
// depends on bb3_pkg; three stages ending in the output register
`default_nettype none

module bb3_average (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  bb3_pkg::t_emit_ctl  i_ctl,
    input  bb3_pkg::t_window    i_win,
    output logic                o_valid,
    output bb3_pkg::t_out_req   o_req
);
    import bb3_pkg::*;

    t_emit_ctl                         r1_ctl;
    logic [2:0][2:0][COLSUM_W-1:0]     r1_colsum, n1_colsum;
    logic                              r2_valid;
    logic                              r2_frame_end;
    logic [2:0][NUM_W-1:0]             r2_num, n2_num;
    logic [RECIP_W-1:0]                r2_recip;
    logic [CNT_W-1:0]                  count;
    logic [2:0][SUM_W-1:0]             sum;
    logic [2:0][PROD_W-1:0]            prod;
    logic                              r_out_valid;
    t_out_req                          r_out_req;

    // stage 1: rows inside the image, per column and channel
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int ch = 0; ch < 3; ch++) begin
                n1_colsum[c][ch] =
                    (i_ctl.has_top ? COLSUM_W'(i_win[c][0][PIX_W-1-CH_W*ch -: CH_W]) : '0)
                  + COLSUM_W'(i_win[c][1][PIX_W-1-CH_W*ch -: CH_W])
                  + (i_ctl.has_bottom ? COLSUM_W'(i_win[c][2][PIX_W-1-CH_W*ch -: CH_W]) : '0);
            end
        end
    end

    // stage 2: columns inside the image, then 2*sum + count
    always_comb begin
        count = tap_count(r1_ctl.has_left, r1_ctl.has_right,
                          r1_ctl.has_top, r1_ctl.has_bottom);
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = (r1_ctl.has_left ? SUM_W'(r1_colsum[0][ch]) : '0)
                    + SUM_W'(r1_colsum[1][ch])
                    + (r1_ctl.has_right ? SUM_W'(r1_colsum[2][ch]) : '0);
            n2_num[ch] = {sum[ch], 1'b0} + NUM_W'(count);
        end
    end

    // stage 3: divide by 2*count through the reciprocal
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = PROD_W'(r2_num[ch]) * PROD_W'(r2_recip);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl      <= '0;
            r2_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r1_ctl      <= i_ctl;
            r2_valid    <= r1_ctl.valid;
            r_out_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_colsum              <= n1_colsum;
            r2_num                 <= n2_num;
            r2_recip               <= recip(count);
            r2_frame_end           <= r1_ctl.frame_end;
            r_out_req.red_out      <= prod[0][RECIP_SHIFT +: CH_W];
            r_out_req.green_out    <= prod[1][RECIP_SHIFT +: CH_W];
            r_out_req.blue_out     <= prod[2][RECIP_SHIFT +: CH_W];
            r_out_req.frame_end    <= r2_frame_end;
        end
    end

    assign o_valid = r_out_valid;
    assign o_req   = r_out_req;

endmodule

`default_nettype wire
